// ===== rtl/core/ipl4x_pkg.sv =====
// shared types and constants for the ethernet ipv4 l4 header extractor
`default_nettype none

package ipl4x_pkg;

  // frame length as carried to the back end, wide enough for the default counter setting
  localparam int FLEN_W          = 16;
  localparam int MAX_FRAME_DFLT  = 16383;
  localparam int PLEN_W          = 14;
  localparam int POFF_W          = 6;
  localparam int QUEUE_DEPTH     = 2;

  // header byte positions within the frame
  localparam int POS_ETYPE_HI    = 12;
  localparam int POS_ETYPE_LO    = 13;
  localparam int POS_FRAG_HI     = 20;
  localparam int POS_FRAG_LO     = 21;
  localparam int POS_PROTO       = 23;
  localparam int POS_SRC_FIRST   = 26;
  localparam int POS_SRC_LAST    = 29;
  localparam int POS_DST_FIRST   = 30;
  localparam int POS_DST_LAST    = 33;
  localparam int POS_PORT_FIRST  = 34;
  localparam int POS_PORT_LAST   = 37;
  localparam int POS_TCP_FLAGS   = 47;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // payload start offsets
  localparam logic [POFF_W-1:0] OFF_LINK    = 6'd14;
  localparam logic [POFF_W-1:0] OFF_IPV4    = 6'd34;
  localparam logic [POFF_W-1:0] OFF_ARP     = 6'd30;
  localparam logic [POFF_W-1:0] OFF_TCP     = 6'd54;
  localparam logic [POFF_W-1:0] OFF_UDP     = 6'd42;

  localparam logic [PLEN_W-1:0] PLEN_MAX    = 14'h3FFF;

  // payload layer register codes
  localparam logic [1:0] LAYER_LINK     = 2'd0;
  localparam logic [1:0] LAYER_DATAGRAM = 2'd1;
  localparam logic [1:0] LAYER_SESSION  = 2'd2;

  // transport kind codes
  localparam logic [1:0] XPORT_NONE  = 2'd0;
  localparam logic [1:0] XPORT_TCP   = 2'd1;
  localparam logic [1:0] XPORT_UDP   = 2'd2;
  localparam logic [1:0] XPORT_OTHER = 2'd3;

  // header fields of one finished frame
  typedef struct packed {
    logic [FLEN_W-1:0] flen;
    logic [15:0]       etype;
    logic [12:0]       frag;
    logic [7:0]        proto;
    logic [31:0]       src;
    logic [31:0]       dst;
    logic [31:0]       ports;
    logic [2:0]        flags;
  } frame_rec_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipl4x_if.sv =====
// request channel interfaces for frame bytes and header summaries
`default_nettype none

interface ipl4x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipl4x_out_if;
  logic        valid;
  logic        ready;
  logic        is_ipv4;
  logic        first_fragment;
  logic [1:0]  transport_kind;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic        ports_valid;
  logic [2:0]  tcp_flag_bits;
  logic [5:0]  payload_offset;
  logic [13:0] payload_length;
  logic        payload_valid;

  modport source (output valid, output is_ipv4, output first_fragment,
                  output transport_kind, output source_address, output dest_address,
                  output source_port, output dest_port, output ports_valid,
                  output tcp_flag_bits, output payload_offset, output payload_length,
                  output payload_valid, input ready);
  modport sink   (input valid, input is_ipv4, input first_fragment,
                  input transport_kind, input source_address, input dest_address,
                  input source_port, input dest_port, input ports_valid,
                  input tcp_flag_bits, input payload_offset, input payload_length,
                  input payload_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipl4x_front.sv =====
// byte counter and header field capture, emits one record per frame
`default_nettype none

module ipl4x_front #(
  parameter int MAX_FRAME_BYTES = ipl4x_pkg::MAX_FRAME_DFLT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire logic [7:0]             in_data_i,
  input  wire logic                   in_last_i,
  output logic                        in_ready_o,
  input  wire logic                   q_full_i,
  output logic                        push_o,
  output ipl4x_pkg::frame_rec_t       push_rec_o
);
  import ipl4x_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [CNT_W-1:0] pos_q, pos_d;
  logic [15:0]      etype_q, etype_d;
  logic [12:0]      frag_q, frag_d;
  logic [7:0]       proto_q, proto_d;
  logic [31:0]      src_q, src_d;
  logic [31:0]      dst_q, dst_d;
  logic [31:0]      ports_q, ports_d;
  logic [2:0]       flags_q, flags_d;
  logic             acc;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc && in_last_i;

  always_comb begin
    etype_d = etype_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    ports_d = ports_q;
    flags_d = flags_q;
    if (pos_q == CNT_W'(POS_ETYPE_HI) || pos_q == CNT_W'(POS_ETYPE_LO)) begin
      etype_d = {etype_q[7:0], in_data_i};
    end else if (pos_q == CNT_W'(POS_FRAG_HI)) begin
      frag_d = {in_data_i[4:0], 8'h00};
    end else if (pos_q == CNT_W'(POS_FRAG_LO)) begin
      frag_d = frag_q | {5'b0, in_data_i};
    end else if (pos_q == CNT_W'(POS_PROTO)) begin
      proto_d = in_data_i;
    end else if (pos_q >= CNT_W'(POS_SRC_FIRST) && pos_q <= CNT_W'(POS_SRC_LAST)) begin
      src_d = {src_q[23:0], in_data_i};
    end else if (pos_q >= CNT_W'(POS_DST_FIRST) && pos_q <= CNT_W'(POS_DST_LAST)) begin
      dst_d = {dst_q[23:0], in_data_i};
    end else if (pos_q >= CNT_W'(POS_PORT_FIRST) && pos_q <= CNT_W'(POS_PORT_LAST)) begin
      ports_d = {ports_q[23:0], in_data_i};
    end else if (pos_q == CNT_W'(POS_TCP_FLAGS)) begin
      flags_d = in_data_i[2:0];
    end
    // byte count holds at its ceiling
    if (pos_q < CNT_W'(MAX_FRAME_BYTES)) begin
      pos_d = pos_q + CNT_W'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  always_comb begin
    push_rec_o.flen  = FLEN_W'(pos_d);
    push_rec_o.etype = etype_d;
    push_rec_o.frag  = frag_d;
    push_rec_o.proto = proto_d;
    push_rec_o.src   = src_d;
    push_rec_o.dst   = dst_d;
    push_rec_o.ports = ports_d;
    push_rec_o.flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      etype_q <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      ports_q <= '0;
      flags_q <= '0;
    end else if (acc) begin
      if (in_last_i) begin
        pos_q   <= '0;
        etype_q <= '0;
        frag_q  <= '0;
        proto_q <= '0;
        src_q   <= '0;
        dst_q   <= '0;
        ports_q <= '0;
        flags_q <= '0;
      end else begin
        pos_q   <= pos_d;
        etype_q <= etype_d;
        frag_q  <= frag_d;
        proto_q <= proto_d;
        src_q   <= src_d;
        dst_q   <= dst_d;
        ports_q <= ports_d;
        flags_q <= flags_d;
      end
    end
  end

  // a finished frame clears the capture state
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == '0) && (etype_q == '0))
    else $error("capture state not cleared after last byte");

endmodule

`default_nettype wire

// ===== rtl/core/ipl4x_queue.sv =====
// short record queue between capture front and summary back end
`default_nettype none

module ipl4x_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire ipl4x_pkg::frame_rec_t  push_rec_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output logic                        pop_valid_o,
  output ipl4x_pkg::frame_rec_t       pop_rec_o
);
  import ipl4x_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_rec_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_o      = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign do_pop      = pop_i && pop_valid_o;
  assign pop_rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("record pushed into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/ipl4x_back.sv =====
// summary decode, payload location and output register
`default_nettype none

module ipl4x_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_wdata_i,
  input  wire logic                   rec_valid_i,
  input  wire ipl4x_pkg::frame_rec_t  rec_i,
  output logic                        pop_o,
  ipl4x_out_if.source                 out_if
);
  import ipl4x_pkg::*;

  logic              valid_q;
  logic [1:0]        layer_q;
  logic [1:0]        layer;
  logic              ipv4, first, tcp, udp, ports_ok, has_pay, pay_ok;
  logic [1:0]        kind;
  logic [POFF_W-1:0] poff;
  logic [FLEN_W-1:0] diff;
  logic [PLEN_W-1:0] plen;

  assign pop_o    = rec_valid_i && (!valid_q || out_if.ready);
  assign out_if.valid = valid_q;

  always_comb begin
    ipv4     = rec_i.etype == ETYPE_IPV4;
    first    = ipv4 && (rec_i.frag == '0);
    tcp      = ipv4 && (rec_i.proto == PROTO_TCP);
    udp      = ipv4 && (rec_i.proto == PROTO_UDP);
    ports_ok = first && (tcp || udp);
    if (!ipv4) begin
      kind = XPORT_NONE;
    end else if (tcp) begin
      kind = XPORT_TCP;
    end else if (udp) begin
      kind = XPORT_UDP;
    end else begin
      kind = XPORT_OTHER;
    end
    // later fragments carry no l4 header
    layer = layer_q;
    if (layer_q == LAYER_SESSION && ipv4 && !first) begin
      layer = LAYER_DATAGRAM;
    end
    has_pay = 1'b0;
    poff    = '0;
    case (layer)
      LAYER_LINK: begin
        has_pay = 1'b1;
        poff    = OFF_LINK;
      end
      LAYER_DATAGRAM: begin
        if (ipv4) begin
          has_pay = 1'b1;
          poff    = OFF_IPV4;
        end else if (rec_i.etype == ETYPE_ARP) begin
          has_pay = 1'b1;
          poff    = OFF_ARP;
        end
      end
      LAYER_SESSION: begin
        if (first && tcp) begin
          has_pay = 1'b1;
          poff    = OFF_TCP;
        end else if (first && udp) begin
          has_pay = 1'b1;
          poff    = OFF_UDP;
        end
      end
      default: begin
        has_pay = 1'b0;
        poff    = '0;
      end
    endcase
    pay_ok = has_pay && (rec_i.flen >= FLEN_W'(poff));
    diff   = rec_i.flen - FLEN_W'(poff);
    if (!pay_ok) begin
      plen = '0;
    end else if (diff > FLEN_W'(PLEN_MAX)) begin
      plen = PLEN_MAX;
    end else begin
      plen = diff[PLEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      layer_q <= LAYER_SESSION;
    end else begin
      if (cfg_we_i) begin
        layer_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        valid_q <= 1'b1;
      end else if (out_if.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_if.is_ipv4        <= ipv4;
      out_if.first_fragment <= first;
      out_if.transport_kind <= kind;
      out_if.source_address <= ipv4 ? rec_i.src : '0;
      out_if.dest_address   <= ipv4 ? rec_i.dst : '0;
      out_if.source_port    <= ports_ok ? rec_i.ports[31:16] : '0;
      out_if.dest_port      <= ports_ok ? rec_i.ports[15:0] : '0;
      out_if.ports_valid    <= ports_ok;
      out_if.tcp_flag_bits  <= (first && tcp) ? rec_i.flags : '0;
      out_if.payload_offset <= poff;
      out_if.payload_length <= plen;
      out_if.payload_valid  <= pay_ok;
    end
  end

  a_ports_need_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_if.ports_valid) |->
      (out_if.first_fragment &&
       (out_if.transport_kind == XPORT_TCP || out_if.transport_kind == XPORT_UDP)))
    else $error("ports flagged valid without first-fragment tcp or udp");

  a_payload_has_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_if.payload_valid) |-> (out_if.payload_offset != '0))
    else $error("valid payload without an offset");

endmodule

`default_nettype wire

// ===== rtl/core/eth_ipv4_l4_header_extract_top.sv =====
// top level of the ethernet ipv4 l4 header extractor
`default_nettype none

// Takes an ethernet frame one byte per request on in_if, starting at the
// destination mac, and returns one summary request on out_if for the byte
// marked last_byte: ipv4 / first fragment flags, transport kind, ip addresses,
// l4 ports, tcp fin/syn/rst and the offset and length of the payload at the
// layer chosen by the payload_layer register (cfg_we_i / cfg_wdata_i, reset
// session). The block takes one byte every cycle while the queue is not full;
// the front end only counts and captures fixed header positions, and the
// summary for a frame passes through the queue to the output register. A
// two-entry record queue sits between capture and decode, so input bytes
// keep flowing while a summary waits on out_if; input stalls only once both
// queue entries and the output register hold frames not yet taken. Write
// payload_layer only while no frame is in flight. The byte count holds at
// MAX_FRAME_BYTES and payload lengths saturate at 16383.
module eth_ipv4_l4_header_extract_top #(
  parameter int MAX_FRAME_BYTES = ipl4x_pkg::MAX_FRAME_DFLT
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_wdata_i,
  ipl4x_in_if.sink        in_if,
  ipl4x_out_if.source     out_if
);
  import ipl4x_pkg::*;

  // records handed from capture to decode
  logic       push, q_full, pop, q_valid;
  frame_rec_t push_rec, pop_rec;

  // capture: byte position and header fields of the current frame
  ipl4x_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_data_i  (in_if.data_byte),
    .in_last_i  (in_if.last_byte),
    .in_ready_o (in_if.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  // decoupling queue, one entry per finished frame
  ipl4x_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rec_i  (push_rec),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_rec_o   (pop_rec)
  );

  // decode and output register
  ipl4x_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_valid_i (q_valid),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire
